@@ design/ctep_pkg.sv @@
// shared types and constants for the call stack exclusive time profiler
package ctep_pkg;

    localparam int ID_W      = 8;
    localparam int TS_W      = 32;
    localparam int TOT_W     = 48;
    localparam int DEPTH_W   = 7;
    localparam int CNT_W     = 9;
    localparam int ELAP_W    = TS_W + 2;
    localparam int MAX_IDS   = 1 << ID_W;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;

    localparam logic [CNT_W-1:0] FUNC_COUNT_RST = 9'd256;

    typedef enum logic [1:0] {
        OP_START,
        OP_END,
        OP_READ
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MISMATCH,
        ST_OVERFLOW,
        ST_BAD_ID
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WR1,
        S_RD2,
        S_WR2,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op              op;
        logic             id_ok;
        logic [ID_W-1:0]  id;
        logic [TS_W-1:0]  ts;
    } t_evt;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [TS_W-1:0]  t0;
    } t_frame;

endpackage

@@ design/ctep_if.sv @@
// event and result channel interfaces
interface ctep_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  func_id;
    logic [31:0] timestamp;

    modport source (output valid, output kind, output func_id, output timestamp,
                    input ready);
    modport sink   (input valid, input kind, input func_id, input timestamp,
                    output ready);
endinterface

interface ctep_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [7:0]         result_id;
    logic signed [47:0] exclusive_total;
    logic [6:0]         call_depth;

    modport source (output valid, output status, output result_id,
                    output exclusive_total, output call_depth, input ready);
    modport sink   (input valid, input status, input result_id,
                    input exclusive_total, input call_depth, output ready);
endinterface

@@ design/ctep_front.sv @@
// front end: event intake, kind decode, id range check and a two-entry queue
module ctep_front #(
    parameter int NUM_FUNCS = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [ctep_pkg::CNT_W-1:0] i_function_count,
    ctep_in_if.sink                  i_evt,
    output ctep_pkg::t_evt           o_head,
    output logic                     o_head_valid,
    input  logic                     i_pop
);
    import ctep_pkg::*;

    t_evt       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_evt       evt;

    assign i_evt.ready = (r_cnt != 2'd2);
    assign push        = i_evt.valid && i_evt.ready;

    always_comb begin
        unique case (i_evt.kind)
            KIND_START: evt.op = OP_START;
            KIND_END:   evt.op = OP_END;
            default:    evt.op = OP_READ;   // unused kind behaves as a read
        endcase
        evt.id    = i_evt.func_id;
        evt.ts    = i_evt.timestamp;
        evt.id_ok = ({1'b0, i_evt.func_id} < i_function_count) &&
                    (32'(i_evt.func_id) < NUM_FUNCS);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    assign o_head       = r_q[r_rp];
    assign o_head_valid = (r_cnt != 2'd0);

endmodule

@@ design/ctep_back.sv @@
// back end: call stack, totals memory and the update sequencer
module ctep_back #(
    parameter int NUM_FUNCS   = 256,
    parameter int STACK_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ctep_pkg::t_evt i_head,
    input  logic           i_head_valid,
    output logic           o_pop,
    ctep_out_if.source     o_res
);
    import ctep_pkg::*;

    localparam int TBL_DEPTH = (NUM_FUNCS < MAX_IDS) ? NUM_FUNCS : MAX_IDS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int SW        = $clog2(STACK_DEPTH);
    localparam int SPW       = $clog2(STACK_DEPTH + 1);
    localparam logic signed [TOT_W:0] SUM_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [TOT_W:0] SUM_MIN = 49'sh1_8000_0000_0000;

    function automatic logic signed [TOT_W-1:0] sat_add(
        input logic signed [TOT_W-1:0]  a,
        input logic signed [ELAP_W-1:0] b
    );
        logic signed [TOT_W:0] s;
        s = (TOT_W+1)'(a) + (TOT_W+1)'(b);
        if (s > SUM_MAX) begin
            sat_add = SUM_MAX[TOT_W-1:0];
        end else if (s < SUM_MIN) begin
            sat_add = SUM_MIN[TOT_W-1:0];
        end else begin
            sat_add = s[TOT_W-1:0];
        end
    endfunction

    // memories
    t_frame                  r_stk_mem [STACK_DEPTH];
    t_frame                  r_stk_rd;
    logic signed [TOT_W-1:0] r_tot_mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0]    r_tvalid;
    logic signed [TOT_W-1:0] r_tot_rd;
    logic                    r_tot_rd_vld;

    // sequencer state
    t_state                   r_state, n_state;
    logic [SPW-1:0]           r_sp, n_sp;
    t_frame                   r_top, n_top;
    t_op                      r_op, n_op;
    logic [ID_W-1:0]          r_id, n_id;
    t_status                  r_status, n_status;
    logic signed [ELAP_W-1:0] r_elapsed, n_elapsed;
    logic                     r_has_caller, n_has_caller;
    logic signed [TOT_W-1:0]  r_sum, n_sum;
    logic signed [TOT_W-1:0]  r_total, n_total;

    // output register
    logic                     r_out_vld;
    t_status                  r_out_status;
    logic [ID_W-1:0]          r_out_id;
    logic signed [TOT_W-1:0]  r_out_total;
    logic [DEPTH_W-1:0]       r_out_depth;
    logic                     out_load;

    // memory controls
    logic [TBL_AW-1:0]        tot_raddr;
    logic                     tot_we;
    logic [TBL_AW-1:0]        tot_waddr;
    logic                     stk_we;
    logic [SW-1:0]            stk_waddr;
    logic [SW-1:0]            stk_raddr;

    logic [SPW-1:0]           sp_m1;
    logic [SPW-1:0]           sp_m2;
    logic signed [TOT_W-1:0]  cur;
    logic signed [TOT_W-1:0]  cur2;
    t_status                  st;

    assign sp_m1 = r_sp - SPW'(1);
    assign sp_m2 = r_sp - SPW'(2);
    assign cur   = r_tot_rd_vld ? r_tot_rd : '0;
    // recursive caller: the first update is still in flight
    assign cur2  = (r_top.id == r_id) ? r_sum : cur;

    always_comb begin
        n_state      = r_state;
        n_sp         = r_sp;
        n_top        = r_top;
        n_op         = r_op;
        n_id         = r_id;
        n_status     = r_status;
        n_elapsed    = r_elapsed;
        n_has_caller = r_has_caller;
        n_sum        = r_sum;
        n_total      = r_total;
        tot_raddr    = i_head.id[TBL_AW-1:0];
        tot_we       = 1'b0;
        tot_waddr    = r_id[TBL_AW-1:0];
        stk_we       = 1'b0;
        stk_waddr    = sp_m1[SW-1:0];
        stk_raddr    = sp_m2[SW-1:0];
        o_pop        = 1'b0;
        out_load     = 1'b0;
        st           = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    if (!i_head.id_ok) begin
                        st = ST_BAD_ID;
                    end else begin
                        unique case (i_head.op)
                            OP_START: st = (r_sp == SPW'(STACK_DEPTH)) ? ST_OVERFLOW : ST_OK;
                            OP_END:   st = ((r_sp == '0) || (r_top.id != i_head.id)) ?
                                           ST_MISMATCH : ST_OK;
                            default:  st = ST_OK;
                        endcase
                    end
                    n_op         = i_head.op;
                    n_id         = i_head.id;
                    n_status     = st;
                    n_elapsed    = $signed({2'b00, i_head.ts}) - $signed({2'b00, r_top.t0})
                                   + ELAP_W'(1);
                    n_has_caller = (r_sp >= SPW'(2));
                    if (st != ST_OK) begin
                        n_total = '0;
                        n_state = S_OUT;
                    end else begin
                        if (i_head.op == OP_START) begin
                            // the old top goes into the memory, the new call stays in flops
                            stk_we = (r_sp != '0);
                            n_top  = '{id: i_head.id, t0: i_head.ts};
                            n_sp   = r_sp + SPW'(1);
                        end
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_op == OP_END) begin
                    n_sum   = sat_add(cur, r_elapsed);
                    n_total = n_sum;
                    n_sp    = sp_m1;
                    n_top   = r_stk_rd;
                    n_state = S_WR1;
                end else begin
                    n_total = cur;
                    n_state = S_OUT;
                end
            end
            S_WR1: begin
                tot_we    = 1'b1;
                tot_raddr = r_top.id[TBL_AW-1:0];
                n_state   = r_has_caller ? S_RD2 : S_OUT;
            end
            S_RD2: begin
                n_sum = sat_add(cur2, -r_elapsed);
                if (r_top.id == r_id) begin
                    n_total = n_sum;
                end
                n_state = S_WR2;
            end
            S_WR2: begin
                tot_we    = 1'b1;
                tot_waddr = r_top.id[TBL_AW-1:0];
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_vld || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_waddr] <= r_top;
        end
        r_stk_rd <= r_stk_mem[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tot_we) begin
            r_tot_mem[tot_waddr] <= r_sum;
        end
        r_tot_rd <= r_tot_mem[tot_raddr];
    end

    // an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid     <= '0;
            r_tot_rd_vld <= 1'b0;
        end else begin
            if (tot_we) begin
                r_tvalid[tot_waddr] <= 1'b1;
            end
            r_tot_rd_vld <= r_tvalid[tot_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sp      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_op         <= n_op;
        r_id         <= n_id;
        r_status     <= n_status;
        r_elapsed    <= n_elapsed;
        r_has_caller <= n_has_caller;
        r_sum        <= n_sum;
        r_total      <= n_total;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_id     <= r_id;
            r_out_total  <= r_total;
            r_out_depth  <= DEPTH_W'(r_sp);
        end
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.status          = r_out_status;
    assign o_res.result_id       = r_out_id;
    assign o_res.exclusive_total = r_out_total;
    assign o_res.call_depth      = r_out_depth;

endmodule

@@ design/call_stack_exclusive_time_profiler.sv @@
// path to a result: a rejected event goes straight to S_OUT, start and read pass S_RD,
// an end passes S_RD and S_WR1 and, with a caller, also S_RD2 and S_WR2; the next
// event is popped only after the result is loaded; an end costs a read-modify-write
// pass on the totals memory for the ended function and one more for its caller, if any
// synchronous reset clears stack pointer, queue, totals valid bits and sets
// function_count to 256; no clearing pass
module call_stack_exclusive_time_profiler #(
    parameter int NUM_FUNCS   = 256,
    parameter int STACK_DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ctep_pkg::CNT_W-1:0] i_cfg_wdata,
    ctep_in_if.sink                    i_evt,
    ctep_out_if.source                 o_res
);
    import ctep_pkg::*;

    logic [CNT_W-1:0] r_function_count;
    t_evt             head;
    logic             head_valid;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_function_count <= FUNC_COUNT_RST;
        end else if (i_cfg_we) begin
            r_function_count <= i_cfg_wdata;
        end
    end

    ctep_front #(
        .NUM_FUNCS (NUM_FUNCS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_function_count (r_function_count),
        .i_evt            (i_evt),
        .o_head           (head),
        .o_head_valid     (head_valid),
        .i_pop            (pop)
    );

    ctep_back #(
        .NUM_FUNCS   (NUM_FUNCS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_res        (o_res)
    );

endmodule
